// File: hw/rtl/depth_pixel_pair_reconstruct_top_defines.svh
// Assertion macros shared by the depth pixel pair checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DEPTH_PIXEL_PAIR_RECONSTRUCT_TOP_DEFINES_SVH
`define DEPTH_PIXEL_PAIR_RECONSTRUCT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while dis is high
`define DPPR_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while dis is high
`define DPPR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/dppr_pkg.sv
// Shared types, widths and constants of the depth pixel pair reconstruction.
// No dependencies; imported by every other file of the block but the macro header.
package dppr_pkg;

    localparam int CODE_W    = 11;   // configured code width
    localparam int JOIN_W    = 12;   // joined high/low code
    localparam int WIDE_W    = 13;   // rescaled code before dequantization
    localparam int PROD_W    = 23;   // scaled numerator
    localparam int DEPTH_W   = 14;   // millimetres
    localparam int BYTE_W    = 8;
    localparam int NIB_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam int SCALE_DIV  = 2047;
    localparam int SCALE_BIAS = 1023;

    localparam logic [CODE_W-1:0] MIN_CODE_RST = 11'd0;
    localparam logic [CODE_W-1:0] MAX_CODE_RST = 11'd2047;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 14'd11824;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CODE = 1'b1;

    // Rescale selection, settled when a register is written
    typedef enum logic [2:0] {
        MODE_PASS  = 3'b001,
        MODE_SHIFT = 3'b010,
        MODE_SCALE = 3'b100
    } t_rescale_mode;

    typedef struct packed {
        t_rescale_mode     mode;
        logic [CODE_W-1:0] range;
        logic [CODE_W-1:0] min_code;
    } t_cfg_ctl;

    // Piecewise-linear dequantization to millimetres
    function automatic logic [DEPTH_W-1:0] dequant(input logic [WIDE_W-1:0] code);
        logic [DEPTH_W-1:0] d;
        logic [DEPTH_W-1:0] res;
        d = DEPTH_W'(code);
        if (d == '0) begin
            res = '0;
        end else if (d < 14'd550) begin
            res = d + 14'd200;
        end else if (d < 14'd925) begin
            res = 14'd750 + ((d - 14'd550) << 1);
        end else if (d < 14'd1300) begin
            res = 14'd1500 + ((d - 14'd925) << 2);
        end else if (d < 14'd1675) begin
            res = 14'd3000 + ((d - 14'd1300) << 3);
        end else if (d < 14'd2040) begin
            res = 14'd6000 + ((d - 14'd1675) << 4);
        end else begin
            res = '0;   // invalid code
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/dppr_in_if.sv
// Input channel: one packed high byte and two low bytes per beat.
// Depends on dppr_pkg for field widths.
interface dppr_in_if import dppr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] high_pair;
    logic [BYTE_W-1:0] low_first;
    logic [BYTE_W-1:0] low_second;

    modport source (output valid, high_pair, low_first, low_second, input ready);
    modport sink   (input valid, high_pair, low_first, low_second, output ready);
endinterface

// File: hw/rtl/dppr_out_if.sv
// Output channel: two depths in millimetres per beat.
// Depends on dppr_pkg for field widths.
interface dppr_out_if import dppr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_first;
    logic [DEPTH_W-1:0] depth_second;

    modport source (output valid, depth_first, depth_second, input ready);
    modport sink   (input valid, depth_first, depth_second, output ready);
endinterface

// File: hw/rtl/dppr_cfg.sv
// Frame code span registers and the rescale mode derived from them.
// Depends on dppr_pkg.
module dppr_cfg import dppr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CODE_W-1:0]    i_cfg_data,
    output t_cfg_ctl             o_ctl
);
    logic [CODE_W-1:0] r_min_code, n_min_code;
    logic [CODE_W-1:0] r_max_code, n_max_code;
    t_rescale_mode     r_mode, n_mode;
    logic [CODE_W-1:0] r_range, n_range;
    logic [CODE_W-1:0] diff;

    // register write
    always_comb begin
        n_min_code = r_min_code;
        n_max_code = r_max_code;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_CODE: n_min_code = i_cfg_data;
                CFG_MAX_CODE: n_max_code = i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify range = max - min + 1
    always_comb begin
        diff    = n_max_code - n_min_code;
        n_range = '0;
        if (n_max_code >= n_min_code) begin
            if (diff == '1) begin
                n_mode = MODE_PASS;          // full span
            end else if (diff == '0) begin
                n_mode = MODE_SHIFT;         // single code
            end else begin
                n_mode  = MODE_SCALE;
                n_range = diff + 11'd1;
            end
        end else if (diff == '1) begin
            n_mode = MODE_SHIFT;             // max just below min: empty span
        end else begin
            n_mode = MODE_PASS;              // wrapped span
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_code <= MIN_CODE_RST;
            r_max_code <= MAX_CODE_RST;
            r_mode     <= MODE_PASS;
            r_range    <= '0;
        end else begin
            r_min_code <= n_min_code;
            r_max_code <= n_max_code;
            r_mode     <= n_mode;
            r_range    <= n_range;
        end
    end

    assign o_ctl.mode     = r_mode;
    assign o_ctl.range    = r_range;
    assign o_ctl.min_code = r_min_code;
endmodule

// File: hw/rtl/dppr_pixel.sv
// Rebuild, rescale and dequantize one depth pixel, purely combinational.
// Depends on dppr_pkg.
module dppr_pixel import dppr_pkg::*; (
    input  logic [NIB_W-1:0]   i_nibble,
    input  logic [BYTE_W-1:0]  i_low,
    input  t_cfg_ctl           i_cfg,
    output logic [DEPTH_W-1:0] o_depth
);
    logic [NIB_W-1:0]  hi;
    logic [BYTE_W-1:0] low_f;
    logic [JOIN_W-1:0] x;
    logic [JOIN_W-1:0] xm1;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] num;
    logic [JOIN_W-1:0] q0;
    logic [WIDE_W-1:0] rem;
    logic [WIDE_W-1:0] quot;
    logic [WIDE_W-1:0] code;

    // join high part and (folded) low byte
    always_comb begin
        hi    = i_nibble - 4'd1;
        low_f = hi[0] ? ~i_low : i_low;
        x     = {hi, low_f};
        if (x == '0) begin
            x = 12'd1;
        end
        xm1 = x - 12'd1;
    end

    // n / 2047 with n = q0*2048 + lo: remainder lo + q0 stays below 3*2047
    always_comb begin
        prod = PROD_W'(xm1) * PROD_W'(i_cfg.range);
        num  = prod + PROD_W'(SCALE_BIAS);
        q0   = num[PROD_W-1:CODE_W];
        rem  = WIDE_W'(num[CODE_W-1:0]) + WIDE_W'(q0);
        quot = WIDE_W'(q0)
             + WIDE_W'(rem >= WIDE_W'(SCALE_DIV))
             + WIDE_W'(rem >= WIDE_W'(2 * SCALE_DIV));
    end

    // rescale select
    always_comb begin
        case (i_cfg.mode)
            MODE_PASS:  code = WIDE_W'(x);
            MODE_SHIFT: code = WIDE_W'(xm1) + WIDE_W'(i_cfg.min_code);
            MODE_SCALE: code = quot + WIDE_W'(i_cfg.min_code);
            default:    code = WIDE_W'(x);
        endcase
    end

    assign o_depth = (i_nibble == '0) ? '0 : dequant(code);
endmodule

// File: hw/rtl/depth_pixel_pair_reconstruct_top.sv
// Top level of the depth pixel pair reconstruction.
// Depends on dppr_pkg, dppr_in_if, dppr_out_if, dppr_cfg and dppr_pixel.
//
// Usage:
//   i_in_ch carries one beat per pixel pair: high_pair (low nibble first
//   pixel, high nibble second), low_first and low_second. o_out_ch returns
//   one beat per input beat with depth_first and depth_second in mm.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes min_code
//   (index 0) or max_code (index 1); write only while no beat is in flight.
//   A beat accepted into the input register runs through the rebuild,
//   rescale and dequantization logic into the output register, which
//   drives o_out_ch. One beat per cycle is sustained while the receiver is
//   ready; the input register and output register form a two-deep pipeline.
//   If the receiver stalls, the output beat holds; an empty input register
//   still takes one more beat, then ready drops until the output drains.
//   Synchronous reset empties both stages and sets min_code to 0 and
//   max_code to 2047 (pass-through rescale).
module depth_pixel_pair_reconstruct_top import dppr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dppr_in_if.sink              i_in_ch,
    dppr_out_if.source           o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CODE_W-1:0]    i_cfg_data
);
    t_cfg_ctl cfg_ctl;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_high_pair;
    logic [BYTE_W-1:0] r_low_first;
    logic [BYTE_W-1:0] r_low_second;

    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_depth_first;
    logic [DEPTH_W-1:0] r_depth_second;

    logic [DEPTH_W-1:0] depth_first;
    logic [DEPTH_W-1:0] depth_second;

    logic out_free;
    logic s1_free;
    logic in_take;

    dppr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_ctl      (cfg_ctl)
    );

    // handshake: each stage loads when it is empty or being drained
    assign out_free = !r_out_valid || o_out_ch.ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign in_take  = i_in_ch.valid && s1_free;
    assign i_in_ch.ready = s1_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_high_pair  <= i_in_ch.high_pair;
            r_low_first  <= i_in_ch.low_first;
            r_low_second <= i_in_ch.low_second;
        end
    end

    // per-pixel datapath
    dppr_pixel u_pix_first (
        .i_nibble (r_high_pair[NIB_W-1:0]),
        .i_low    (r_low_first),
        .i_cfg    (cfg_ctl),
        .o_depth  (depth_first)
    );

    dppr_pixel u_pix_second (
        .i_nibble (r_high_pair[BYTE_W-1:NIB_W]),
        .i_low    (r_low_second),
        .i_cfg    (cfg_ctl),
        .o_depth  (depth_second)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_depth_first  <= depth_first;
            r_depth_second <= depth_second;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.depth_first  = r_depth_first;
    assign o_out_ch.depth_second = r_depth_second;
endmodule

// File: hw/rtl/dppr_checker.sv
// Port-level checks of the depth pixel pair top, attached by bind.
// Depends on dppr_pkg and depth_pixel_pair_reconstruct_top_defines.svh.
`include "depth_pixel_pair_reconstruct_top_defines.svh"

module dppr_checker import dppr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DEPTH_W-1:0] i_depth_first,
    input logic [DEPTH_W-1:0] i_depth_second
);
    // reset empties the pipeline
    `DPPR_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !i_out_valid, "output valid after reset")

    // an empty output stage never blocks the input
    `DPPR_ASSERT_SAME(a_no_bubble, i_clk, !i_rst_n, !i_out_valid, i_in_ready, "input blocked while output empty")

    // a stalled beat holds
    `DPPR_ASSERT_NEXT(a_stall_hold, i_clk, !i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_depth_first) && $stable(i_depth_second), "stalled beat changed")

    // depths stay within the dequantized span
    `DPPR_ASSERT_SAME(a_depth_span, i_clk, !i_rst_n, i_out_valid, (i_depth_first <= DEPTH_MAX) && (i_depth_second <= DEPTH_MAX), "depth out of span")
endmodule

bind depth_pixel_pair_reconstruct_top dppr_checker u_dppr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in_ch.ready),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_depth_first  (o_out_ch.depth_first),
    .i_depth_second (o_out_ch.depth_second)
);

// File: verif/depth_pixel_pair_reconstruct_top_tb.sv
// Self-checking testbench for the depth pixel pair reconstruction top level.
// Depends on dppr_pkg, dppr_in_if, dppr_out_if and depth_pixel_pair_reconstruct_top.
// Drives pixel pairs and code settings, and checks every output beat against a predictor.
module depth_pixel_pair_reconstruct_top_tb;
    import dppr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 60;
    localparam int TAIL_CYCLES = 4;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [DEPTH_W-1:0] depth_first;
        logic [DEPTH_W-1:0] depth_second;
    } t_depth_pair;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CODE_W-1:0]    cfg_data;

    dppr_in_if  in_ch();
    dppr_out_if out_ch();

    depth_pixel_pair_reconstruct_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predictor copy of the code registers
    logic [CODE_W-1:0] min_code_q;
    logic [CODE_W-1:0] max_code_q;

    t_depth_pair pending_depths[$];

    int err_count     = 0;
    int pairs_sent    = 0;
    int beats_checked = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    always #10 i_clk = ~i_clk;

    // Code to millimetres, piecewise linear
    function automatic logic [DEPTH_W-1:0] code_to_mm(input int q);
        int mm;
        if (q == 0)         mm = 0;
        else if (q < 550)   mm = q + 200;
        else if (q < 925)   mm = 750 + (q - 550) * 2;
        else if (q < 1300)  mm = 1500 + (q - 925) * 4;
        else if (q < 1675)  mm = 3000 + (q - 1300) * 8;
        else if (q < 2040)  mm = 6000 + (q - 1675) * 16;
        else                mm = 0;
        return DEPTH_W'(mm);
    endfunction

    // One pixel: unfold, join, rescale to the configured span, dequantize
    function automatic logic [DEPTH_W-1:0] pixel_depth(input logic [NIB_W-1:0] nib,
                                                       input logic [BYTE_W-1:0] lo);
        int hi;
        int b;
        int x;
        int rng;
        int q;
        int mn;
        if (nib == '0) return '0;
        hi = int'(nib) - 1;
        b  = int'(lo);
        if (hi % 2 == 1) b = 255 - b;
        x = b | (hi << 8);
        if (x == 0) x = 1;
        mn  = int'(min_code_q);
        rng = int'(max_code_q) - mn + 1;
        if (rng < 0 || rng >= 2048) q = x;
        else if (rng <= 1)          q = x - 1 + mn;
        else                        q = ((x - 1) * rng + 1023) / 2047 + mn;
        return code_to_mm(q);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at beat %0d: %s got %0d expected %0d",
                     beats_checked, what, got, want);
    endtask

    // Send one pixel pair; returns at the falling edge after acceptance
    task automatic send_pair(input logic [BYTE_W-1:0] hp, input logic [BYTE_W-1:0] l0,
                             input logic [BYTE_W-1:0] l1);
        t_depth_pair want;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.high_pair  <= hp;
        in_ch.low_first  <= l0;
        in_ch.low_second <= l1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        want.depth_first  = pixel_depth(hp[3:0], l0);
        want.depth_second = pixel_depth(hp[7:4], l1);
        pending_depths.push_back(want);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    // Split a joined code into its nibble and stored (possibly folded) low byte
    task automatic split_code(input int code, output logic [NIB_W-1:0] nib,
                              output logic [BYTE_W-1:0] lo);
        int hi;
        int b;
        hi = code >> 8;
        b  = code & 255;
        if (hi % 2 == 1) b = 255 - b;
        nib = NIB_W'(hi + 1);
        lo  = BYTE_W'(b);
    endtask

    task automatic send_codes(input int c0, input int c1);
        logic [NIB_W-1:0]  n0;
        logic [NIB_W-1:0]  n1;
        logic [BYTE_W-1:0] l0;
        logic [BYTE_W-1:0] l1;
        split_code(c0, n0, l0);
        split_code(c1, n1, l1);
        send_pair({n1, n0}, l0, l1);
    endtask

    // Sender stops; wait until every expected beat has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_depths.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write both code registers; only called with the block idle
    task automatic set_codes(input int mn, input int mx);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MIN_CODE;
        cfg_data <= CODE_W'(mn);
        @(negedge i_clk);
        cfg_idx  <= CFG_MAX_CODE;
        cfg_data <= CODE_W'(mx);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        min_code_q = CODE_W'(mn);
        max_code_q = CODE_W'(mx);
        settings_used++;
    endtask

    // Random setting, weighted toward the rescale corner cases
    task automatic pick_setting(output int mn, output int mx);
        case ($urandom_range(7))
            0: begin
                mn = 0;
                mx = 2047;
            end
            1: begin
                mn = $urandom_range(2047);
                mx = mn;
            end
            2: begin
                mn = $urandom_range(2047, 1);
                mx = mn - 1;
            end
            3: begin
                mn = $urandom_range(2047, 2);
                mx = $urandom_range(mn - 2);
            end
            4: begin
                mn = 0;
                mx = $urandom_range(2046, 1);
            end
            5: begin
                mn = $urandom_range(2046);
                mx = $urandom_range(2047, mn + 1);
            end
            6: begin
                mn = $urandom_range(2047, 1);
                mx = 2047;
            end
            default: begin
                mn = $urandom_range(1) ? 2047 : 0;
                mx = (mn == 0) ? 1 : 0;
            end
        endcase
    endtask

    function automatic logic [NIB_W-1:0] rand_nibble();
        case ($urandom_range(9))
            0:       return '0;
            1:       return NIB_W'(1);
            2:       return NIB_W'(15);
            default: return NIB_W'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_low();
        case ($urandom_range(9))
            0:       return '0;
            1:       return BYTE_W'(255);
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    // Dequantization breakpoints, empty nibbles and the forced minimum code
    task automatic test_code_breakpoints();
        src_idle_pct = 20;
        rcv_idle_pct = 20;
        send_pair(8'h00, 8'h5A, 8'hA5);
        send_pair(8'h11, 8'h00, 8'h00);
        send_pair(8'hFF, 8'hFF, 8'h00);
        send_codes(1, 255);
        send_codes(256, 511);
        send_codes(549, 550);
        send_codes(924, 925);
        send_codes(1299, 1300);
        send_codes(1674, 1675);
        send_codes(2039, 2040);
        send_codes(2047, 2048);
        drain_results();
    endtask

    // Each rescale branch at its extremes
    task automatic test_rescale_modes();
        set_codes(0, 0);            // range of one
        send_codes(1, 2047);
        send_codes(2040, 2);
        drain_results();
        set_codes(5, 4);            // range of zero
        send_codes(1, 2047);
        drain_results();
        set_codes(2047, 2047);
        send_codes(1, 3839);
        drain_results();
        set_codes(1, 2047);         // widest scaled range
        send_codes(1, 2047);
        send_codes(1024, 3839);
        drain_results();
        set_codes(0, 1);            // narrowest scaled range
        send_codes(1, 3839);
        drain_results();
        set_codes(2047, 0);         // wrapped range
        send_codes(1, 2039);
        drain_results();
        set_codes(100, 50);
        send_codes(600, 1800);
        drain_results();
    endtask

    // Random pairs in groups, a new setting per group
    task automatic test_random_traffic(input int src_pct, input int rcv_pct, input int n_items);
        int done;
        int mn;
        int mx;
        src_idle_pct = src_pct;
        rcv_idle_pct = rcv_pct;
        done = 0;
        while (done < n_items) begin
            pick_setting(mn, mx);
            set_codes(mn, mx);
            for (int k = 0; k < 40 && done < n_items; k++) begin
                send_pair({rand_nibble(), rand_nibble()}, rand_low(), rand_low());
                done++;
            end
            drain_results();
        end
    endtask

    // Receiver holds off while the sender keeps offering; the block must stall its input
    task automatic test_output_stall();
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 30; k++)
            send_pair({rand_nibble(), rand_nibble()}, rand_low(), rand_low());
        drain_results();
    endtask

    // Sender pauses mid-stream until everything has drained, then resumes
    task automatic test_source_pause();
        src_idle_pct = 10;
        rcv_idle_pct = 30;
        for (int k = 0; k < 10; k++)
            send_pair({rand_nibble(), rand_nibble()}, rand_low(), rand_low());
        drain_results();
        for (int k = 0; k < 10; k++)
            send_pair({rand_nibble(), rand_nibble()}, rand_low(), rand_low());
        drain_results();
    endtask

    // Receiver: random idling, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Compare each output beat with the oldest expected pair
    always @(posedge i_clk) begin
        t_depth_pair want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_depths.size() == 0) begin
                report_mismatch("unexpected beat depth_first", int'(out_ch.depth_first), -1);
            end else begin
                want = pending_depths.pop_front();
                if (out_ch.depth_first !== want.depth_first)
                    report_mismatch("depth_first", int'(out_ch.depth_first),
                                    int'(want.depth_first));
                if (out_ch.depth_second !== want.depth_second)
                    report_mismatch("depth_second", int'(out_ch.depth_second),
                                    int'(want.depth_second));
            end
            beats_checked++;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats outstanding",
                 cycle_count, pending_depths.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_MIN_CODE;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.high_pair  = '0;
        in_ch.low_first  = '0;
        in_ch.low_second = '0;
        out_ch.ready     = 1'b0;
        min_code_q       = MIN_CODE_RST;
        max_code_q       = MAX_CODE_RST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_code_breakpoints();
        test_rescale_modes();
        test_random_traffic(29, 54, 530);
        test_output_stall();
        test_random_traffic(54, 29, 530);
        test_source_pause();
        test_random_traffic(0, 0, 530);

        // Let any stray beat show up before the verdict
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (pending_depths.size() != 0) begin
            report_mismatch("missing beat depth_first", -1,
                            int'(pending_depths[0].depth_first));
            void'(pending_depths.pop_front());
        end

        $display("covered %0d pixel pairs under %0d code settings, %0d output beats compared",
                 pairs_sent, settings_used, beats_checked);
        $display("traffic mixed source and sink idling, a long output stall and a source pause");
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
